[hw/rtl/dead_reckoning_position_integrator_assert.svh]
// Assertion macros for the dead-reckoning position integrator checker.
// Needs aclk and aresetn in the scope that uses them.
`ifndef DEAD_RECKONING_POSITION_INTEGRATOR_ASSERT_SVH
`define DEAD_RECKONING_POSITION_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define DRPI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("drpi check failed");

// Next-cycle implication, disabled while reset is asserted
`define DRPI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("drpi check failed");

`endif

[hw/rtl/drpi_pkg.sv]
// Shared types, constants and tables for the dead-reckoning position integrator.
// No dependencies; every other RTL module refers to it by scoped names.
package drpi_pkg;

    // Build-time sizing
    localparam int CORDIC_ITERATIONS = 16;
    localparam int POSITION_WIDTH    = 40;
    localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);
    localparam int OUT_POS_W         = 40;
    localparam int POS_SUM_W         = POSITION_WIDTH + 1;

    // APB port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Angles in 1/16 degree
    localparam int HALF_TURN    = 2880;
    localparam int FULL_TURN    = 5760;
    localparam int QUARTER_TURN = 1440;

    // Degree-to-binary-angle conversion: a * 2^32 / 5760 = a * 2^25 / 45
    localparam int TURN_DIV      = 45;
    localparam int RECIP_45      = 1457;
    localparam int RECIP_SHIFT   = 16;
    localparam int BAM_PER_STEP  = 745654;
    localparam int BAM_ROUND_R   = 23;
    localparam int BAM_K_SHIFT   = 25;

    // CORDIC start gain, Q1.30
    localparam int CORDIC_K_Q30 = 652032874;

    // Shared multiplier and product accumulator
    localparam int MUL_W      = 24;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SPLIT_W    = 18;
    localparam int P_MAG_W    = 2 * SPLIT_W;
    localparam int ACC_W      = 60;
    localparam int FRAC_SHIFT = 30;

    // Position limits
    localparam logic signed [POSITION_WIDTH-1:0] POS_MAX =
        {1'b0, {(POSITION_WIDTH-1){1'b1}}};
    localparam logic signed [POSITION_WIDTH-1:0] POS_MIN =
        {1'b1, {(POSITION_WIDTH-1){1'b0}}};

    // Register reset values
    localparam int SPEED_GAIN_RST    = 18186;
    localparam int STEP_SCALE_RST    = 25166;
    localparam int SEND_INTERVAL_RST = 150;

    typedef enum logic [1:0] {
        REG_ENABLE        = 2'd0,
        REG_SPEED_GAIN    = 2'd1,
        REG_STEP_SCALE    = 2'd2,
        REG_SEND_INTERVAL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] speed_gain;
        logic [23:0] step_scale;
        logic [15:0] send_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic        mul_en;
        logic        acc_load;
        logic        acc_add;
    } mac_cmd_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [31:0] angle;
    } cordic_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_SPD,
        ST_MUL_P,
        ST_ANGLE,
        ST_ZQ,
        ST_ZR,
        ST_CORDIC,
        ST_TRIG,
        ST_MXL,
        ST_MXH,
        ST_ACX,
        ST_SAT_X,
        ST_MYL,
        ST_MYH,
        ST_ACY,
        ST_SAT_Y,
        ST_DONE
    } dr_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROTATE,
        CS_FINISH
    } cordic_state_t;

    // Arctangent of 2^-i in binary angle units (2^32 per turn)
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/drpi_regs.sv]
// APB configuration registers of the position integrator.
// Depends on drpi_pkg for register indexes, reset values and cfg_t.
module drpi_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [drpi_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [drpi_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [drpi_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output drpi_pkg::cfg_t                    cfg
);

    drpi_pkg::cfg_t      cfg_reg;
    drpi_pkg::reg_idx_t  idx;
    logic                wr_en;

    assign idx    = drpi_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable           <= 1'b0;
            cfg_reg.speed_gain       <= 16'(drpi_pkg::SPEED_GAIN_RST);
            cfg_reg.step_scale       <= 24'(drpi_pkg::STEP_SCALE_RST);
            cfg_reg.send_interval_ms <= 16'(drpi_pkg::SEND_INTERVAL_RST);
        end else if (wr_en) begin
            unique case (idx)
                drpi_pkg::REG_ENABLE:        cfg_reg.enable           <= pwdata[0];
                drpi_pkg::REG_SPEED_GAIN:    cfg_reg.speed_gain       <= pwdata[15:0];
                drpi_pkg::REG_STEP_SCALE:    cfg_reg.step_scale       <= pwdata[23:0];
                drpi_pkg::REG_SEND_INTERVAL: cfg_reg.send_interval_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (idx)
            drpi_pkg::REG_ENABLE:        prdata = 32'(cfg_reg.enable);
            drpi_pkg::REG_SPEED_GAIN:    prdata = 32'(cfg_reg.speed_gain);
            drpi_pkg::REG_STEP_SCALE:    prdata = 32'(cfg_reg.step_scale);
            drpi_pkg::REG_SEND_INTERVAL: prdata = 32'(cfg_reg.send_interval_ms);
            default:                     prdata = '0;
        endcase
    end

endmodule

[hw/rtl/drpi_mac.sv]
// Shared 24x24 unsigned multiplier with a product accumulator.
// Depends on drpi_pkg for widths and the mac_cmd_t command struct.
module drpi_mac (
    input  logic                           aclk,
    input  drpi_pkg::mac_cmd_t             cmd,
    input  logic [drpi_pkg::MUL_W-1:0]     op_a,
    input  logic [drpi_pkg::MUL_W-1:0]     op_b,
    output logic [drpi_pkg::PROD_W-1:0]    prod,
    output logic [drpi_pkg::ACC_W-1:0]     acc
);

    logic [drpi_pkg::PROD_W-1:0] prod_reg;
    logic [drpi_pkg::ACC_W-1:0]  acc_reg;
    logic [drpi_pkg::ACC_W-1:0]  hi_part;

    assign prod    = prod_reg;
    assign acc     = acc_reg;
    assign hi_part = (drpi_pkg::ACC_W)'({prod_reg, {drpi_pkg::SPLIT_W{1'b0}}});

    // Register the product, then load it as the lower or add it as the upper partial product
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= (drpi_pkg::PROD_W)'(op_a) * (drpi_pkg::PROD_W)'(op_b);
        end
        priority if (cmd.acc_load) begin
            acc_reg <= (drpi_pkg::ACC_W)'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + hi_part;
        end
    end

endmodule

[hw/rtl/drpi_cordic.sv]
// Iterative CORDIC rotator: one shift-add step per cycle, cos/sin in Q1.30.
// Depends on drpi_pkg for the iteration count, start gain and atan table.
module drpi_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  drpi_pkg::cordic_req_t req,
    output logic                  done,
    output logic signed [31:0]    cos_out,
    output logic signed [31:0]    sin_out
);

    drpi_pkg::cordic_state_t         state_reg, state_next;
    logic [drpi_pkg::ITER_W-1:0]     iter_reg;
    logic signed [31:0]              x_reg, y_reg, z_reg;
    logic                            neg_reg;
    logic                            done_reg;
    logic                            load, rotate, finish, last;
    logic signed [31:0]              dx, dy, atan_c;

    assign last    = (iter_reg == (drpi_pkg::ITER_W)'(drpi_pkg::CORDIC_ITERATIONS - 1));
    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

    // Sequence: load, rotate N times, fold the sign back
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            drpi_pkg::CS_IDLE:   if (req.start) state_next = drpi_pkg::CS_ROTATE;
            drpi_pkg::CS_ROTATE: if (last) state_next = drpi_pkg::CS_FINISH;
            drpi_pkg::CS_FINISH: state_next = drpi_pkg::CS_IDLE;
            default:             state_next = drpi_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        load   = 1'b0;
        rotate = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            drpi_pkg::CS_IDLE:   load   = req.start;
            drpi_pkg::CS_ROTATE: rotate = 1'b1;
            drpi_pkg::CS_FINISH: finish = 1'b1;
            default: ;
        endcase
    end

    // One micro-rotation
    assign dx     = y_reg >>> iter_reg;
    assign dy     = x_reg >>> iter_reg;
    assign atan_c = signed'(drpi_pkg::atan_bam(5'(iter_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= drpi_pkg::CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= finish;
        end
    end

    always_ff @(posedge aclk) begin
        priority if (load) begin
            x_reg    <= 32'(drpi_pkg::CORDIC_K_Q30);
            y_reg    <= '0;
            z_reg    <= signed'(req.angle);
            neg_reg  <= req.neg;
            iter_reg <= '0;
        end else if (rotate) begin
            if (!z_reg[31]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_c;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_c;
            end
            iter_reg <= iter_reg + 1'b1;
        end else if (finish && neg_reg) begin
            x_reg <= -x_reg;
            y_reg <= -y_reg;
        end
    end

endmodule

[hw/rtl/dead_reckoning_position_integrator.sv]
// Top level of the 2-D dead-reckoning position integrator: sequencer and datapath.
// Depends on drpi_pkg, drpi_regs, drpi_mac and drpi_cordic.
//
// Each tick item carries elapsed milliseconds, IMU yaw (1/16 degree) and wheel speed
// (cm/s). The millisecond timer accumulates on every tick. A tick that arrives while
// enable is 0 is absorbed in its accept cycle and s_ready stays high. An enabled tick
// runs through one shared 24x24 multiplier and one iterative CORDIC unit and keeps
// s_ready low until the sequencer returns to ST_IDLE. The CORDIC loop runs one
// rotation per cycle. The multiplier forms the corrected speed and the step product,
// and four of its passes form the X and Y partial products. When the timer has
// reached send_interval_ms on an enabled tick, one result item is written to the
// output register. It holds there until m_ready takes it. If an older result still
// waits, the block stalls at the end of the tick. Registers sit on an APB port:
// enable at 0x0, speed_gain at 0x4, step_scale at 0x8 and send_interval_ms at 0xC.
module dead_reckoning_position_integrator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [drpi_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [drpi_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [drpi_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [9:0]                       s_elapsed_ms,
    input  logic signed [13:0]               s_yaw_angle,
    input  logic signed [10:0]               s_wheel_speed,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [12:0]               m_heading_out,
    output logic signed [39:0]               m_x_position,
    output logic signed [39:0]               m_y_position_neg,
    output logic signed [12:0]               m_speed_out
);

    drpi_pkg::cfg_t         cfg;
    drpi_pkg::dr_state_t    state_reg, state_next;
    drpi_pkg::mac_cmd_t     mac_cmd;
    drpi_pkg::cordic_req_t  cordic_req;

    logic [drpi_pkg::MUL_W-1:0]   mac_a, mac_b;
    logic [drpi_pkg::PROD_W-1:0]  prod;
    logic [drpi_pkg::ACC_W-1:0]   acc;
    logic                         cordic_done;
    logic signed [31:0]           cos_q30, sin_q30;

    logic                         s_accept;
    logic [16:0]                  timer_sum;
    logic [15:0]                  timer_sat;
    logic                         report_c;
    logic                         load_out;

    // Control and accumulated state
    logic [15:0]                  timer_reg;
    logic                         report_reg;
    logic signed [drpi_pkg::POSITION_WIDTH-1:0] pos_x_reg, pos_y_reg;
    logic                         m_valid_reg;

    // Per-item payload
    logic signed [13:0]           yaw_reg;
    logic signed [10:0]           spd_reg;
    logic [11:0]                  corr_mag_reg;
    logic signed [12:0]           corr_reg;
    logic [drpi_pkg::P_MAG_W-1:0] p_mag_reg;
    logic signed [13:0]           sh_reg;
    logic [10:0]                  amag_reg;
    logic                         asign_reg, fold_reg;
    logic [5:0]                   k_reg;
    logic [23:0]                  cmag_reg, smag_reg;
    logic                         csign_reg, ssign_reg;

    // Output registers
    logic signed [12:0]           heading_reg, speed_reg;
    logic signed [39:0]           x_out_reg, y_out_reg;

    // Combinational datapath terms
    logic [10:0]                  spd_mag_c;
    logic [11:0]                  corr_mag_c;
    logic signed [13:0]           sh_c, wrap_c, fold_c;
    logic                         fold_flag_c;
    logic [10:0]                  k45_c;
    logic [5:0]                   r_c;
    logic [31:0]                  zmag_c, z_c;
    logic signed [23:0]           c8_c, s8_c;
    logic signed [drpi_pkg::POSITION_WIDTH-1:0] pos_sel_c, sat_c, ny_c;
    logic                         neg_sel_c;
    logic [drpi_pkg::POS_SUM_W-1:0] pos_ext_c, dmag_c, delta_c, sum_c;

    drpi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drpi_mac u_mac (
        .aclk (aclk),
        .cmd  (mac_cmd),
        .op_a (mac_a),
        .op_b (mac_b),
        .prod (prod),
        .acc  (acc)
    );

    drpi_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .done    (cordic_done),
        .cos_out (cos_q30),
        .sin_out (sin_q30)
    );

    assign s_ready  = (state_reg == drpi_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Saturating millisecond timer and report decision
    assign timer_sum = 17'(timer_reg) + 17'(s_elapsed_ms);
    assign timer_sat = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
    assign report_c  = (timer_sat >= cfg.send_interval_ms);

    // Speed magnitude and corrected-speed magnitude taken from the product
    assign spd_mag_c  = spd_reg[10] ? 11'(-spd_reg) : 11'(spd_reg);
    assign corr_mag_c = prod[25:14];

    // Shift yaw by a half turn, wrap into one turn, fold into +/- a quarter turn
    always_comb begin
        sh_c = yaw_reg[13] ? yaw_reg + 14'(drpi_pkg::HALF_TURN)
                           : yaw_reg - 14'(drpi_pkg::HALF_TURN);
        priority if (sh_c >= 14'(drpi_pkg::HALF_TURN)) begin
            wrap_c = sh_c - 14'(drpi_pkg::FULL_TURN);
        end else if (sh_c < -14'(drpi_pkg::HALF_TURN)) begin
            wrap_c = sh_c + 14'(drpi_pkg::FULL_TURN);
        end else begin
            wrap_c = sh_c;
        end
        fold_flag_c = 1'b1;
        priority if (wrap_c > 14'(drpi_pkg::QUARTER_TURN)) begin
            fold_c = wrap_c - 14'(drpi_pkg::HALF_TURN);
        end else if (wrap_c < -14'(drpi_pkg::QUARTER_TURN)) begin
            fold_c = wrap_c + 14'(drpi_pkg::HALF_TURN);
        end else begin
            fold_c      = wrap_c;
            fold_flag_c = 1'b0;
        end
    end

    // Binary angle: k * 2^25 + floor(r * 2^25 / 45), with |a| = 45k + r
    assign k45_c  = 11'(k_reg) * 11'(drpi_pkg::TURN_DIV);
    assign r_c    = 6'(amag_reg - k45_c);
    assign zmag_c = (32'(k_reg) << drpi_pkg::BAM_K_SHIFT)
                  + 32'(r_c) * 32'(drpi_pkg::BAM_PER_STEP)
                  + 32'(r_c >= 6'(drpi_pkg::BAM_ROUND_R));
    assign z_c    = asign_reg ? -zmag_c : zmag_c;

    // Trig values scaled to Q.22
    assign c8_c = 24'(cos_q30 >>> 8);
    assign s8_c = 24'(sin_q30 >>> 8);

    // Shared saturating accumulate for X and Y
    always_comb begin
        pos_sel_c = (state_reg == drpi_pkg::ST_SAT_Y) ? pos_y_reg : pos_x_reg;
        neg_sel_c = corr_reg[12]
                  ^ ((state_reg == drpi_pkg::ST_SAT_Y) ? ssign_reg : csign_reg);
        pos_ext_c = (drpi_pkg::POS_SUM_W)'(pos_sel_c);
        dmag_c    = (drpi_pkg::POS_SUM_W)'(acc[drpi_pkg::ACC_W-1:drpi_pkg::FRAC_SHIFT]);
        delta_c   = neg_sel_c ? (~dmag_c + (drpi_pkg::POS_SUM_W)'(1)) : dmag_c;
        sum_c     = pos_ext_c + delta_c;
        if (sum_c[drpi_pkg::POS_SUM_W-1] != sum_c[drpi_pkg::POS_SUM_W-2]) begin
            sat_c = sum_c[drpi_pkg::POS_SUM_W-1] ? drpi_pkg::POS_MIN : drpi_pkg::POS_MAX;
        end else begin
            sat_c = signed'(sum_c[drpi_pkg::POSITION_WIDTH-1:0]);
        end
    end

    assign ny_c = (pos_y_reg == drpi_pkg::POS_MIN) ? drpi_pkg::POS_MAX : -pos_y_reg;

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            drpi_pkg::ST_IDLE:    if (s_accept && cfg.enable) state_next = drpi_pkg::ST_MUL_SPD;
            drpi_pkg::ST_MUL_SPD: state_next = drpi_pkg::ST_MUL_P;
            drpi_pkg::ST_MUL_P:   state_next = drpi_pkg::ST_ANGLE;
            drpi_pkg::ST_ANGLE:   state_next = drpi_pkg::ST_ZQ;
            drpi_pkg::ST_ZQ:      state_next = drpi_pkg::ST_ZR;
            drpi_pkg::ST_ZR:      state_next = drpi_pkg::ST_CORDIC;
            drpi_pkg::ST_CORDIC:  if (cordic_done) state_next = drpi_pkg::ST_TRIG;
            drpi_pkg::ST_TRIG:    state_next = drpi_pkg::ST_MXL;
            drpi_pkg::ST_MXL:     state_next = drpi_pkg::ST_MXH;
            drpi_pkg::ST_MXH:     state_next = drpi_pkg::ST_ACX;
            drpi_pkg::ST_ACX:     state_next = drpi_pkg::ST_SAT_X;
            drpi_pkg::ST_SAT_X:   state_next = drpi_pkg::ST_MYL;
            drpi_pkg::ST_MYL:     state_next = drpi_pkg::ST_MYH;
            drpi_pkg::ST_MYH:     state_next = drpi_pkg::ST_ACY;
            drpi_pkg::ST_ACY:     state_next = drpi_pkg::ST_SAT_Y;
            drpi_pkg::ST_SAT_Y:   state_next = drpi_pkg::ST_DONE;
            drpi_pkg::ST_DONE: begin
                if (!report_reg || !m_valid_reg || m_ready) state_next = drpi_pkg::ST_IDLE;
            end
            default:              state_next = drpi_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: unit commands and operand selection
    always_comb begin
        mac_cmd          = '0;
        mac_a            = '0;
        mac_b            = '0;
        cordic_req.start = 1'b0;
        cordic_req.neg   = fold_reg;
        cordic_req.angle = z_c;
        load_out         = 1'b0;
        unique case (state_reg)
            drpi_pkg::ST_MUL_SPD: begin
                mac_cmd.mul_en = 1'b1;
                mac_a          = 24'(spd_mag_c);
                mac_b          = 24'(cfg.speed_gain);
            end
            drpi_pkg::ST_MUL_P: begin
                mac_cmd.mul_en = 1'b1;
                mac_a          = 24'(corr_mag_c);
                mac_b          = cfg.step_scale;
            end
            drpi_pkg::ST_ZR: cordic_req.start = 1'b1;
            drpi_pkg::ST_MXL: begin
                mac_cmd.mul_en = 1'b1;
                mac_a          = 24'(p_mag_reg[drpi_pkg::SPLIT_W-1:0]);
                mac_b          = cmag_reg;
            end
            drpi_pkg::ST_MXH: begin
                mac_cmd.mul_en   = 1'b1;
                mac_cmd.acc_load = 1'b1;
                mac_a            = 24'(p_mag_reg[drpi_pkg::P_MAG_W-1:drpi_pkg::SPLIT_W]);
                mac_b            = cmag_reg;
            end
            drpi_pkg::ST_ACX: mac_cmd.acc_add = 1'b1;
            drpi_pkg::ST_MYL: begin
                mac_cmd.mul_en = 1'b1;
                mac_a          = 24'(p_mag_reg[drpi_pkg::SPLIT_W-1:0]);
                mac_b          = smag_reg;
            end
            drpi_pkg::ST_MYH: begin
                mac_cmd.mul_en   = 1'b1;
                mac_cmd.acc_load = 1'b1;
                mac_a            = 24'(p_mag_reg[drpi_pkg::P_MAG_W-1:drpi_pkg::SPLIT_W]);
                mac_b            = smag_reg;
            end
            drpi_pkg::ST_ACY: mac_cmd.acc_add = 1'b1;
            drpi_pkg::ST_DONE: load_out = report_reg && (!m_valid_reg || m_ready);
            default: ;
        endcase
    end

    // Control state: sequencer, timer, accumulators, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= drpi_pkg::ST_IDLE;
            timer_reg   <= '0;
            report_reg  <= 1'b0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                report_reg <= cfg.enable && report_c;
                timer_reg  <= (cfg.enable && report_c) ? 16'd0 : timer_sat;
            end
            if (state_reg == drpi_pkg::ST_SAT_X) pos_x_reg <= sat_c;
            if (state_reg == drpi_pkg::ST_SAT_Y) pos_y_reg <= sat_c;
            priority if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Per-item payload and output registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            yaw_reg <= s_yaw_angle;
            spd_reg <= s_wheel_speed;
        end
        unique case (state_reg)
            drpi_pkg::ST_MUL_P: corr_mag_reg <= corr_mag_c;
            drpi_pkg::ST_ANGLE: begin
                p_mag_reg <= prod[drpi_pkg::P_MAG_W-1:0];
                corr_reg  <= spd_reg[10] ? -signed'(13'(corr_mag_reg))
                                         : signed'(13'(corr_mag_reg));
                sh_reg    <= sh_c;
                amag_reg  <= fold_c[13] ? 11'(-fold_c) : 11'(fold_c);
                asign_reg <= fold_c[13];
                fold_reg  <= fold_flag_c;
            end
            drpi_pkg::ST_ZQ: begin
                k_reg <= 6'((22'(amag_reg) * 22'(drpi_pkg::RECIP_45)) >> drpi_pkg::RECIP_SHIFT);
            end
            drpi_pkg::ST_TRIG: begin
                cmag_reg  <= c8_c[23] ? 24'(-c8_c) : 24'(c8_c);
                smag_reg  <= s8_c[23] ? 24'(-s8_c) : 24'(s8_c);
                csign_reg <= c8_c[23];
                ssign_reg <= s8_c[23];
            end
            default: ;
        endcase
        if (load_out) begin
            heading_reg <= 13'(-sh_reg);
            x_out_reg   <= (drpi_pkg::OUT_POS_W)'(pos_x_reg);
            y_out_reg   <= (drpi_pkg::OUT_POS_W)'(ny_c);
            speed_reg   <= corr_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_heading_out    = heading_reg;
    assign m_x_position     = x_out_reg;
    assign m_y_position_neg = y_out_reg;
    assign m_speed_out      = speed_reg;

endmodule

[hw/rtl/drpi_checker.sv]
// Port-level checker for the position integrator, bound to the top level.
// Depends on dead_reckoning_position_integrator_assert.svh for its macros.
`include "dead_reckoning_position_integrator_assert.svh"

module drpi_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [drpi_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [drpi_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [drpi_pkg::APB_DATA_W-1:0]  prdata,
    input logic                             pready,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [9:0]                       s_elapsed_ms,
    input logic signed [13:0]               s_yaw_angle,
    input logic signed [10:0]               s_wheel_speed,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [12:0]               m_heading_out,
    input logic signed [39:0]               m_x_position,
    input logic signed [39:0]               m_y_position_neg,
    input logic signed [12:0]               m_speed_out
);

    // Hold a result item until it is taken
    `DRPI_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid)

    // A new result only appears at the end of a busy tick
    `DRPI_ASSERT_IMP(a_out_after_busy, $rose(m_valid), !$past(s_ready))

    // Corrected speed never reaches the most negative code
    `DRPI_ASSERT_IMP(a_speed_range, m_valid, m_speed_out != 13'h1000)

    // Keep the position and heading payload while a result waits
    `DRPI_ASSERT_NXT(a_out_stable, m_valid && !m_ready,
        $stable(m_x_position) && $stable(m_y_position_neg) && $stable(m_heading_out))

endmodule

bind dead_reckoning_position_integrator drpi_checker u_checker (.*);
